[design/spir_pkg.sv]
// Shared constants, types and codes for the square-spiral index-to-offset block.
package spir_pkg;

    localparam int IDX_W      = 18;
    localparam int OFS_W      = 9;
    localparam int ROOT_W     = IDX_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int WORK_W     = ROOT_W + 3;
    localparam int K_W        = ROOT_W + 3;
    localparam int MAX_RADIUS = 255;

    // one token moving down the square-root chain
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } spir_tok_t;

    typedef enum logic [1:0] {
        SIDE_LOW   = 2'd0,
        SIDE_TOP   = 2'd1,
        SIDE_HIGH  = 2'd2,
        SIDE_BOT   = 2'd3
    } spir_side_t;

endpackage

[design/spir_if.sv]
// Valid/ready channel interfaces for spiral index requests and offset responses.
interface spir_req_if;
    logic                          valid;
    logic                          ready;
    logic [spir_pkg::IDX_W-1:0]    spiral_index;

    modport source (output valid, output spiral_index, input ready);
    modport sink   (input valid, input spiral_index, output ready);
endinterface

interface spir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [spir_pkg::OFS_W-1:0] inline_offset;
    logic signed [spir_pkg::OFS_W-1:0] crossline_offset;
    logic                          out_of_range;

    modport source (output valid, output inline_offset, output crossline_offset,
                    output out_of_range, input ready);
    modport sink   (input valid, input inline_offset, input crossline_offset,
                    input out_of_range, output ready);
endinterface

[design/spiral_index_to_offset.sv]
// Top level: square-spiral index to signed inline/crossline offsets.
//
//  channel  dir  payload                                           handshake
//  req      in   spiral_index[17:0]                                valid/ready
//  rsp      out  inline_offset[8:0] s, crossline_offset[8:0] s,    valid/ready
//               out_of_range
//
// One transaction in the root chain and back-end stages at a time. An accepted
// index walks nine root cells (one root bit each), then ring/base, square,
// remainder, side/offset stages and on to the rsp register.
// rst_n clears all valid bits and the busy flag; data registers are not reset.
// A finished result parks in the side/offset register while rsp is stalled, so
// req takes the next transaction as soon as the prior one reaches the rsp register.
module spiral_index_to_offset (
    input  logic              clk,
    input  logic              rst_n,
    spir_req_if.sink          req,
    spir_rsp_if.source        rsp
);

    localparam int R_W = spir_pkg::ROOT_W;

    // ---- control ----
    logic busy_reg;
    logic busy_next;
    logic accept;
    logic res_move;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && req.ready;

    // ---- square-root chain ----
    spir_pkg::spir_tok_t head;
    spir_pkg::spir_tok_t tail;

    always_comb
    begin
        head.valid = accept;
        head.idx   = req.spiral_index;
        head.rad   = req.spiral_index;
        head.rem   = '0;
        head.root  = '0;
    end

    spir_sqrt_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .tail  (tail)
    );

    // ---- stage A: ring radius r = (floor(sqrt(idx)) + 1) / 2, d = 2r - 1 ----
    logic [R_W:0]               s_inc;
    logic [R_W-1:0]             r_a;
    logic                       a_valid_reg;
    logic [spir_pkg::IDX_W-1:0] a_idx_reg;
    logic [R_W-1:0]             a_r_reg;
    logic [R_W-1:0]             a_d_reg;
    logic                       a_zero_reg;
    logic                       a_oor_reg;

    assign s_inc = {1'b0, tail.root} + (R_W+1)'(1);
    assign r_a   = s_inc[R_W:1];

    always_ff @(posedge clk)
    begin
        a_idx_reg  <= tail.idx;
        a_r_reg    <= r_a;
        // 2r-1 wraps correctly at r = 2^(R_W-1)
        a_d_reg    <= {r_a[R_W-2:0], 1'b0} - R_W'(1);
        a_zero_reg <= (tail.idx == '0);
        a_oor_reg  <= (32'(r_a) > 32'(spir_pkg::MAX_RADIUS));
    end

    // ---- stage B: start of ring, (2r-1)^2 ----
    logic                       b_valid_reg;
    logic [spir_pkg::IDX_W-1:0] b_idx_reg;
    logic [R_W-1:0]             b_r_reg;
    logic [2*R_W-1:0]           b_sq_reg;
    logic                       b_zero_reg;
    logic                       b_oor_reg;

    always_ff @(posedge clk)
    begin
        b_idx_reg  <= a_idx_reg;
        b_r_reg    <= a_r_reg;
        b_sq_reg   <= a_d_reg * a_d_reg;
        b_zero_reg <= a_zero_reg;
        b_oor_reg  <= a_oor_reg;
    end

    // ---- stage C: k = idx - (2r-1)^2, below 8r ----
    logic [spir_pkg::IDX_W-1:0] k_full;
    logic                       c_valid_reg;
    logic [spir_pkg::K_W-1:0]   c_k_reg;
    logic [R_W-1:0]             c_r_reg;
    logic                       c_zero_reg;
    logic                       c_oor_reg;

    assign k_full = b_idx_reg - spir_pkg::IDX_W'(b_sq_reg);

    always_ff @(posedge clk)
    begin
        c_k_reg    <= k_full[spir_pkg::K_W-1:0];
        c_r_reg    <= b_r_reg;
        c_zero_reg <= b_zero_reg;
        c_oor_reg  <= b_oor_reg;
    end

    // ---- stage D: side = k / 2r by compares, p = k mod 2r, offsets ----
    logic [spir_pkg::K_W-1:0]   len1;
    logic [spir_pkg::K_W-1:0]   len2;
    logic [spir_pkg::K_W-1:0]   len3;
    logic [spir_pkg::K_W-1:0]   base;
    logic [spir_pkg::K_W-1:0]   p_full;
    spir_pkg::spir_side_t       side;
    logic [spir_pkg::OFS_W-1:0] rv;
    logic [spir_pkg::OFS_W-1:0] pv;
    logic [spir_pkg::OFS_W-1:0] il;
    logic [spir_pkg::OFS_W-1:0] xl;

    assign len1 = spir_pkg::K_W'({c_r_reg, 1'b0});
    assign len2 = spir_pkg::K_W'({c_r_reg, 2'b00});
    assign len3 = len1 + len2;

    always_comb
    begin
        priority if (c_k_reg >= len3)
        begin
            side = spir_pkg::SIDE_BOT;
            base = len3;
        end
        else if (c_k_reg >= len2)
        begin
            side = spir_pkg::SIDE_HIGH;
            base = len2;
        end
        else if (c_k_reg >= len1)
        begin
            side = spir_pkg::SIDE_TOP;
            base = len1;
        end
        else
        begin
            side = spir_pkg::SIDE_LOW;
            base = '0;
        end
    end

    assign p_full = c_k_reg - base;
    assign rv     = spir_pkg::OFS_W'(c_r_reg);
    assign pv     = p_full[spir_pkg::OFS_W-1:0];

    // offsets wrap to the 9-bit field width
    always_comb
    begin
        unique case (side)
            spir_pkg::SIDE_LOW:
            begin
                il = -rv;
                xl = pv - rv;
            end
            spir_pkg::SIDE_TOP:
            begin
                il = pv - rv;
                xl = rv;
            end
            spir_pkg::SIDE_HIGH:
            begin
                il = rv;
                xl = rv - pv;
            end
            spir_pkg::SIDE_BOT:
            begin
                il = rv - pv;
                xl = -rv;
            end
            default:
            begin
                il = '0;
                xl = '0;
            end
        endcase
    end

    // result register doubles as the skid stage ahead of rsp
    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic [spir_pkg::OFS_W-1:0] res_il_reg;
    logic [spir_pkg::OFS_W-1:0] res_xl_reg;
    logic                       res_oor_reg;

    always_ff @(posedge clk)
    begin
        if (c_valid_reg)
        begin
            // centre and beyond-last-ring both report zero offsets
            res_il_reg  <= (c_zero_reg || c_oor_reg) ? '0 : il;
            res_xl_reg  <= (c_zero_reg || c_oor_reg) ? '0 : xl;
            res_oor_reg <= c_oor_reg && !c_zero_reg;
        end
    end

    // ---- rsp register ----
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [spir_pkg::OFS_W-1:0] out_il_reg;
    logic [spir_pkg::OFS_W-1:0] out_xl_reg;
    logic                       out_oor_reg;

    assign res_move = res_valid_reg && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (res_move)
        begin
            out_il_reg  <= res_il_reg;
            out_xl_reg  <= res_xl_reg;
            out_oor_reg <= res_oor_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.inline_offset    = $signed(out_il_reg);
    assign rsp.crossline_offset = $signed(out_xl_reg);
    assign rsp.out_of_range     = out_oor_reg;

    // ---- control registers ----
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (res_move)
        begin
            busy_next = 1'b0;
        end

        res_valid_next = c_valid_reg || (res_valid_reg && !res_move);
        out_valid_next = res_move || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            a_valid_reg   <= tail.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---- assertions ----
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.out_of_range |->
            (rsp.inline_offset == '0) && (rsp.crossline_offset == '0))
        else $error("out-of-range response with nonzero offsets");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tail.valid, a_valid_reg, b_valid_reg, c_valid_reg, res_valid_reg}))
        else $error("more than one transaction in the back-end stages");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |->
            !(tail.valid || a_valid_reg || b_valid_reg || c_valid_reg || res_valid_reg))
        else $error("token in flight while not busy");

    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |=> res_valid_reg && busy_reg)
        else $error("finished result lost before the rsp register");

endmodule

[design/spir_sqrt_cell.sv]
// One restoring square-root cell: resolves one root bit and registers the token.
module spir_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spir_pkg::spir_tok_t tok_in,
    output spir_pkg::spir_tok_t tok_out
);

    logic [spir_pkg::WORK_W-1:0] work;
    logic [spir_pkg::WORK_W-1:0] trial;
    logic [spir_pkg::WORK_W-1:0] diff;
    logic                        ge;
    spir_pkg::spir_tok_t         tok_next;
    logic                        valid_reg;
    spir_pkg::spir_tok_t         data_reg;

    always_comb
    begin
        work  = {tok_in.rem, tok_in.rad[spir_pkg::IDX_W-1 -: 2]};
        trial = {1'b0, tok_in.root, 2'b01};
        diff  = work - trial;
        ge    = (work >= trial);

        tok_next       = tok_in;
        tok_next.rad   = {tok_in.rad[spir_pkg::IDX_W-3:0], 2'b00};
        tok_next.rem   = ge ? diff[spir_pkg::REM_W-1:0] : work[spir_pkg::REM_W-1:0];
        tok_next.root  = {tok_in.root[spir_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = data_reg;
        tok_out.valid = valid_reg;
    end

endmodule

[design/spir_sqrt_chain.sv]
// Row of square-root cells, one root bit per cell, tokens shift every cycle.
module spir_sqrt_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  spir_pkg::spir_tok_t head,
    output spir_pkg::spir_tok_t tail
);

    spir_pkg::spir_tok_t link [0:spir_pkg::ROOT_W];

    assign link[0] = head;

    for (genvar i = 0; i < spir_pkg::ROOT_W; i++)
    begin : g_cell
        spir_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tail = link[spir_pkg::ROOT_W];

endmodule
